/* design/rau_pkg.sv */
package rau_pkg;

  // operation codes
  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_EQ  = 3'd4;
  localparam logic [2:0] OP_GT  = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIV0 = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  // double-width magnitude of a cross product
  localparam int MAG_W = 64;
  typedef logic [MAG_W-1:0] mag_t;
  typedef logic signed [MAG_W-1:0] prod_t;

endpackage

/* design/rau_reduce.sv */
module rau_reduce import rau_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  mag_t num_mag,
  input  mag_t den_mag,
  output logic done,
  output mag_t num_red,
  output mag_t den_red
);

  typedef enum logic [2:0] {R_IDLE, R_EVEN, R_GCD, R_DIVN, R_DIVD} rstate_t;

  rstate_t      state;
  mag_t         x, y, g, rem, quo, num_s, den_s;
  logic [5:0]   k;
  logic [5:0]   cnt;

  logic         x_ge_y;
  mag_t         rem_sh, sub_a, sub_b, rem_next, quo_next;
  logic [MAG_W:0] diff;
  logic         rem_ge;

  // shared subtractor: binary gcd difference or division trial subtract
  always_comb begin
    x_ge_y = (x >= y);
    rem_sh = {rem[MAG_W-2:0], quo[MAG_W-1]};
    if (state == R_GCD) begin
      sub_a = x_ge_y ? x : y;
      sub_b = x_ge_y ? y : x;
    end else begin
      sub_a = rem_sh;
      sub_b = g;
    end
    diff     = {1'b0, sub_a} - {1'b0, sub_b};
    rem_ge   = ~diff[MAG_W];
    rem_next = rem_ge ? diff[MAG_W-1:0] : rem_sh;
    quo_next = {quo[MAG_W-2:0], rem_ge};
  end

  // gcd, then exact division of both magnitudes by it
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= R_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        R_IDLE: begin
          if (start) begin
            x     <= num_mag;
            y     <= den_mag;
            num_s <= num_mag;
            den_s <= den_mag;
            k     <= '0;
            state <= R_EVEN;
          end
        end
        R_EVEN: begin
          if (!x[0] && !y[0]) begin
            x <= x >> 1;
            y <= y >> 1;
            k <= k + 6'd1;
          end else begin
            state <= R_GCD;
          end
        end
        R_GCD: begin
          if (x == '0) begin
            g     <= y << k;
            rem   <= '0;
            quo   <= num_s;
            cnt   <= '0;
            state <= R_DIVN;
          end else if (!x[0]) begin
            x <= x >> 1;
          end else if (!y[0]) begin
            y <= y >> 1;
          end else if (x_ge_y) begin
            x <= diff[MAG_W-1:0] >> 1;
          end else begin
            y <= diff[MAG_W-1:0] >> 1;
          end
        end
        R_DIVN: begin
          rem <= rem_next;
          quo <= quo_next;
          cnt <= cnt + 6'd1;
          if (cnt == 6'd63) begin
            num_red <= quo_next;
            rem     <= '0;
            quo     <= den_s;
            state   <= R_DIVD;
          end
        end
        R_DIVD: begin
          rem <= rem_next;
          quo <= quo_next;
          cnt <= cnt + 6'd1;
          if (cnt == 6'd63) begin
            den_red <= quo_next;
            done    <= 1'b1;
            state   <= R_IDLE;
          end
        end
        default: state <= R_IDLE;
      endcase
    end
  end

endmodule

/* design/rational_arith_unit.sv */
// channel  | handshake           | payload
// ---------+---------------------+----------------------------------------------
// request  | in_valid / in_ready | operation, a_num, a_den, b_num, b_den
// result   | out_valid/out_ready | result_num, result_den, compare_flag, status
//
// add/sub/mul/div pass through S_MUL1, S_MUL2, S_MUL3, the combine state S_COMB,
// the binary gcd loop and two 64-step divisions in the reduction unit.
// comparisons skip S_MUL3 and the reduction; error and unused codes go from S_IDLE to S_FIN.
// the shared 65-bit subtractor in the reduction unit serves both the gcd loop and the divisions.
// rst is synchronous; a new request is taken while a result waits on out_ready.
module rational_arith_unit import rau_pkg::*; #(
  parameter int FIELD_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         operation,
  input  logic signed [31:0] a_num,
  input  logic [30:0]        a_den,
  input  logic signed [31:0] b_num,
  input  logic [30:0]        b_den,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] result_num,
  output logic [30:0]        result_den,
  output logic               compare_flag,
  output logic [1:0]         status
);

  localparam mag_t LIM = (mag_t'(1) << (FIELD_WIDTH - 1)) - mag_t'(1);

  typedef enum logic [2:0] {S_IDLE, S_MUL1, S_MUL2, S_MUL3, S_COMB, S_RED, S_FIN} state_t;

  state_t             state;
  logic [2:0]         op;
  logic signed [31:0] an, bn;
  logic [30:0]        ad, bd;
  prod_t              p1, p2, p3;
  logic               neg;
  mag_t               nmag, dmag;
  logic               red_start;
  logic signed [31:0] r_num;
  logic [30:0]        r_den;
  logic               r_flag;
  logic [1:0]         r_st;

  logic signed [32:0] m_a, m_b;
  logic signed [65:0] m_prod;
  prod_t              n_sum, d_val;
  logic               red_done;
  mag_t               num_red, den_red;

  assign in_ready = (state == S_IDLE);

  // shared multiplier operand select
  always_comb begin
    case (state)
      S_MUL1: begin
        m_a = {an[31], an};
        m_b = (op == OP_MUL) ? {bn[31], bn} : {2'b00, bd};
      end
      S_MUL2: begin
        m_a = {bn[31], bn};
        m_b = {2'b00, ad};
      end
      default: begin
        m_a = {2'b00, ad};
        m_b = {2'b00, bd};
      end
    endcase
    m_prod = m_a * m_b;
  end

  // raw numerator and denominator
  always_comb begin
    case (op)
      OP_ADD:  n_sum = p1 + p2;
      OP_SUB:  n_sum = p1 - p2;
      default: n_sum = p1;
    endcase
    d_val = (op == OP_DIV) ? p2 : p3;
  end

  rau_reduce u_reduce (
    .clk     (clk),
    .rst     (rst),
    .start   (red_start),
    .num_mag (nmag),
    .den_mag (dmag),
    .done    (red_done),
    .num_red (num_red),
    .den_red (den_red)
  );

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      red_start <= 1'b0;
    end else begin
      red_start <= 1'b0;
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op     <= operation;
            an     <= a_num;
            ad     <= a_den;
            bn     <= b_num;
            bd     <= b_den;
            r_num  <= '0;
            r_den  <= 31'd1;
            r_flag <= 1'b0;
            r_st   <= ST_OK;
            if (a_den == '0 || b_den == '0) begin
              r_st  <= ST_DIV0;
              state <= S_FIN;
            end else if (operation > OP_GT) begin
              state <= S_FIN;
            end else if (operation == OP_DIV && b_num == '0) begin
              r_st  <= ST_DIV0;
              state <= S_FIN;
            end else begin
              state <= S_MUL1;
            end
          end
        end
        S_MUL1: begin
          p1    <= m_prod[63:0];
          state <= S_MUL2;
        end
        S_MUL2: begin
          p2    <= m_prod[63:0];
          state <= (op == OP_EQ || op == OP_GT) ? S_COMB : S_MUL3;
        end
        S_MUL3: begin
          p3    <= m_prod[63:0];
          state <= S_COMB;
        end
        S_COMB: begin
          if (op == OP_EQ) begin
            r_flag <= (p1 == p2);
            state  <= S_FIN;
          end else if (op == OP_GT) begin
            r_flag <= (p1 > p2);
            state  <= S_FIN;
          end else if (n_sum == '0) begin
            state <= S_FIN;
          end else begin
            neg       <= n_sum[63] ^ d_val[63];
            nmag      <= n_sum[63] ? mag_t'(-n_sum) : mag_t'(n_sum);
            dmag      <= d_val[63] ? mag_t'(-d_val) : mag_t'(d_val);
            red_start <= 1'b1;
            state     <= S_RED;
          end
        end
        S_RED: begin
          if (red_done) begin
            if (num_red > LIM || den_red > LIM) begin
              r_st <= ST_OVF;
            end else begin
              r_num <= neg ? -$signed(num_red[31:0]) : $signed(num_red[31:0]);
              r_den <= den_red[30:0];
            end
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            result_num   <= r_num;
            result_den   <= r_den;
            compare_flag <= r_flag;
            status       <= r_st;
            out_valid    <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // an error result is always 0/1
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> result_num == '0 && result_den == 31'd1)
    else $error("error result not 0/1");

  // a comparison result carries no fraction
  a_flag_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && compare_flag |-> status == ST_OK && result_num == '0)
    else $error("flag with fraction or error");

  // a delivered denominator is never zero
  a_den_nz: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> result_den != '0)
    else $error("zero denominator");

  // one request at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after accept");

endmodule

/* test/rational_arith_unit_checker.sv */
`timescale 1ns / 1ps
module rational_arith_unit_checker import rau_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [2:0]         operation,
  input  logic signed [31:0] a_num,
  input  logic [30:0]        a_den,
  input  logic signed [31:0] b_num,
  input  logic [30:0]        b_den,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] result_num,
  input  logic [30:0]        result_den,
  input  logic               compare_flag,
  input  logic [1:0]         status,
  output int                 fail_count,
  output int                 pending_count
);

  typedef struct packed {
    logic signed [31:0] num;
    logic [30:0]        den;
    logic               flag;
    logic [1:0]         st;
  } fraction_result_t;

  fraction_result_t expected_q[$];

  // euclid on unsigned magnitudes
  function automatic mag_t common_divisor(mag_t x, mag_t y);
    mag_t t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic fraction_result_t compute_fraction(logic [2:0] op,
      logic signed [31:0] an, logic [30:0] ad, logic signed [31:0] bn, logic [30:0] bd);
    fraction_result_t r;
    prod_t n, d, sad, sbd;
    mag_t mn, md, g, lim;
    logic neg;
    r = '{num: 0, den: 1, flag: 0, st: ST_OK};
    sad = prod_t'({33'd0, ad});
    sbd = prod_t'({33'd0, bd});
    if (ad == 0 || bd == 0) begin
      r.st = ST_DIV0;
      return r;
    end
    case (op)
      OP_ADD: begin n = an * sbd + bn * sad; d = sad * sbd; end
      OP_SUB: begin n = an * sbd - bn * sad; d = sad * sbd; end
      OP_MUL: begin n = prod_t'(an) * prod_t'(bn); d = sad * sbd; end
      OP_DIV: begin
        if (bn == 0) begin
          r.st = ST_DIV0;
          return r;
        end
        n = an * sbd; d = sad * prod_t'(bn);
      end
      OP_EQ: begin r.flag = (an * sbd == sad * bn); return r; end
      OP_GT: begin r.flag = (an * sbd > sad * bn); return r; end
      default: return r;
    endcase
    if (n == 0) return r;
    neg = (n < 0) != (d < 0);
    mn = (n < 0) ? -n : n;
    md = (d < 0) ? -d : d;
    g = common_divisor(mn, md);
    mn = mn / g;
    md = md / g;
    lim = (mag_t'(1) << 31) - 1;
    if (mn > lim || md > lim) begin
      r.st = ST_OVF;
      return r;
    end
    r.num = neg ? -mn[31:0] : mn[31:0];
    r.den = md[30:0];
    return r;
  endfunction

  // predict on request, compare on result
  always @(posedge clk) begin
    fraction_result_t e;
    if (rst) begin
      fail_count <= 0;
      expected_q.delete();
    end else begin
      if (in_valid && in_ready)
        expected_q.push_back(compute_fraction(operation, a_num, a_den, b_num, b_den));
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %0d/%0d", result_num, result_den);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_q.pop_front();
          if (result_num !== e.num || result_den !== e.den || compare_flag !== e.flag ||
              status !== e.st) begin
            if (fail_count < 10)
              $display("mismatch: exp %0d/%0d f%0d s%0d got %0d/%0d f%0d s%0d",
                       e.num, e.den, e.flag, e.st, result_num, result_den,
                       compare_flag, status);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending_count <= expected_q.size();
  end

endmodule

/* test/rational_arith_unit_test.sv */
`timescale 1ns / 1ps
module rational_arith_unit_test import rau_pkg::*;;

  logic               clk = 0;
  logic               rst = 1;
  logic               in_valid = 0;
  logic               in_ready;
  logic [2:0]         operation = OP_ADD;
  logic signed [31:0] a_num = 0;
  logic [30:0]        a_den = 1;
  logic signed [31:0] b_num = 0;
  logic [30:0]        b_den = 1;
  logic               out_valid;
  logic               out_ready = 0;
  logic signed [31:0] result_num;
  logic [30:0]        result_den;
  logic               compare_flag;
  logic [1:0]         status;
  int                 fail_count;
  int                 pending_count;
  int                 cycle_count = 0;
  int                 ready_hold = 0;
  logic               quiet = 0;
  logic               long_hold = 0;

  localparam int CYCLE_LIMIT = 2000000;

  always #5 clk = ~clk;

  rational_arith_unit dut (.*);
  rational_arith_unit_checker checker_inst (.*);

  // numerator: extremes, small values and full random
  function automatic logic signed [31:0] pick_num();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return -32'sh7fffffff;
      2: return $signed($urandom_range(0, 20)) - 10;
      3: return 0;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [30:0] pick_den();
    case ($urandom_range(0, 5))
      0: return 31'h7fffffff;
      1: return 31'd1;
      2: return 31'($urandom_range(1, 30));
      3: return ($urandom_range(0, 40) == 0) ? 31'd0 : 31'd7;
      default: return 31'($urandom);
    endcase
  endfunction

  task automatic send_request(logic [2:0] op, logic signed [31:0] an, logic [30:0] ad,
                              logic signed [31:0] bn, logic [30:0] bd);
    in_valid  <= 1;
    operation <= op;
    a_num     <= an;
    a_den     <= ad;
    b_num     <= bn;
    b_den     <= bd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic sender_gap();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // result side stalls in random bursts, and holds off throughout long_hold
  always @(posedge clk) begin
    if (rst || quiet) begin
      out_ready  <= !rst;
      ready_hold <= 0;
    end else if (long_hold) begin
      out_ready <= 0;
    end else if (ready_hold > 0) begin
      out_ready  <= 0;
      ready_hold <= ready_hold - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_ready  <= 0;
      ready_hold <= $urandom_range(0, 7);
    end else begin
      out_ready <= 1;
    end
  end

  // timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    logic [2:0] op;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: every operation and special cases
    for (int k = 0; k < 8; k++) send_request(3'(k), 3, 4, -5, 6);
    send_request(OP_DIV, 1, 2, 0, 3);
    send_request(OP_ADD, 1, 0, 1, 1);
    send_request(OP_EQ, 1, 1, 2, 0);
    send_request(OP_MUL, 32'sh7fffffff, 1, 32'sh7fffffff, 1);
    send_request(OP_ADD, 32'sh7fffffff, 31'h7fffffff, -32'sh7fffffff, 31'h7fffffff);
    send_request(OP_SUB, 1, 2, 1, 2);
    send_request(OP_DIV, 32'sh80000000, 1, 1, 31'h7fffffff);
    send_request(OP_EQ, 2, 4, 1, 2);
    send_request(OP_GT, -1, 3, -1, 2);
    send_request(OP_MUL, -6, 4, 2, 9);
    send_request(OP_ADD, 32'shffffffff, 31'h55555555, 32'sh2aaaaaaa, 31'h7ffffffe);
    // pause until drained
    in_valid <= 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    // long receiver hold while offering requests
    fork
      begin
        long_hold = 1;
        repeat (2000) @(posedge clk);
        long_hold = 0;
      end
      for (int k = 0; k < 10; k++)
        send_request(OP_EQ, pick_num(), pick_den(), pick_num(), pick_den());
    join
    for (int k = 0; k < 930; k++) begin
      if (k == 830) quiet = 1;
      op = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
      send_request(op, pick_num(), pick_den(), pick_num(), pick_den());
      sender_gap();
    end
    in_valid <= 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
